// ===== rtl/rpcmh_pkg.sv =====
// Shared types, constants and decode helpers for the RPC message header parser.
package rpcmh_pkg;

	localparam int unsigned MAX_MSG_BYTES_DEF = 65536;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CODE_W  = 5;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned LEFT_W  = 17;
	localparam int unsigned CONS_W  = 33;
	localparam int unsigned OPQ_W   = 32;
	localparam int unsigned ACC_W   = 24;

	// address prefix length and the only RPC version decoded
	localparam logic [3:0]        PREFIX_LEN = 4'd12;
	localparam logic [VALUE_W-1:0] RPC_VERS  = 32'd2;

	// message type, reply status, accept status, reject status
	localparam logic [VALUE_W-1:0] MT_CALL       = 32'd0;
	localparam logic [VALUE_W-1:0] MT_REPLY      = 32'd1;
	localparam logic [VALUE_W-1:0] MS_ACCEPTED   = 32'd0;
	localparam logic [VALUE_W-1:0] MS_DENIED     = 32'd1;
	localparam logic [VALUE_W-1:0] AS_SUCCESS    = 32'd0;
	localparam logic [VALUE_W-1:0] AS_PROG_MISM  = 32'd2;
	localparam logic [VALUE_W-1:0] RS_RPC_MISM   = 32'd0;
	localparam logic [VALUE_W-1:0] RS_AUTH_ERROR = 32'd1;

	localparam logic [CODE_W-1:0] FC_END = 5'd29;

	typedef enum logic [4:0] {
		PH_PRE1     = 5'd0,
		PH_HOST     = 5'd1,
		PH_PRE2     = 5'd2,
		PH_LHOST    = 5'd3,
		PH_PORT     = 5'd4,
		PH_LPORT    = 5'd5,
		PH_XID      = 5'd6,
		PH_MTYPE    = 5'd7,
		PH_RPCVERS  = 5'd8,
		PH_PROG     = 5'd9,
		PH_VERS     = 5'd10,
		PH_PROC     = 5'd11,
		PH_CFLAV    = 5'd12,
		PH_CCNT     = 5'd13,
		PH_CDATA    = 5'd14,
		PH_VFLAV    = 5'd15,
		PH_VCNT     = 5'd16,
		PH_VDATA    = 5'd17,
		PH_ARGS     = 5'd18,
		PH_STAT     = 5'd19,
		PH_AVFLAV   = 5'd20,
		PH_AVCNT    = 5'd21,
		PH_AVDATA   = 5'd22,
		PH_ASTAT    = 5'd23,
		PH_RESULTS  = 5'd24,
		PH_PLOW     = 5'd25,
		PH_PHIGH    = 5'd26,
		PH_RSTAT    = 5'd27,
		PH_RLOW     = 5'd28,
		PH_RHIGH    = 5'd29,
		PH_AUTHSTAT = 5'd30
	} ph_t;

	// field code reported for each phase: prefixes and host share code 0
	function automatic logic [CODE_W-1:0] phase_code(input logic [4:0] p);
		logic [CODE_W-1:0] c;
		c = (p >= 5'd3) ? p - 5'd2 : 5'd0;
		return c;
	endfunction

	// word size in bytes, 0 for phases that are not big-endian words
	function automatic logic [2:0] phase_size(input logic [4:0] p);
		logic [2:0] s;
		case (p)
			PH_PRE1, PH_PRE2, PH_CDATA, PH_VDATA, PH_AVDATA,
			PH_ARGS, PH_RESULTS, 5'd31: s = 3'd0;
			PH_PORT, PH_LPORT: s = 3'd2;
			default: s = 3'd4;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/rpcmh_in_if.sv =====
// Byte request channel into the parser: valid/ready with data byte and last mark.
interface rpcmh_in_if import rpcmh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/rpcmh_out_if.sv =====
// Field request channel out of the parser: valid/ready with the decoded field.
interface rpcmh_out_if import rpcmh_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CODE_W-1:0]        field_code;
	logic [VALUE_W-1:0]       field_value;
	logic                     end_of_message;
	logic signed [LEFT_W-1:0] leftover;

	modport source (output valid, output field_code, output field_value,
		output end_of_message, output leftover, input ready);
	modport sink (input valid, input field_code, input field_value,
		input end_of_message, input leftover, output ready);
endinterface

// ===== rtl/rpc_message_header_parser.sv =====
// RPC message header parser: skips address prefixes, decodes call/reply header fields.
//
// Usage:
//   msg : byte requests in (data_byte, last_byte), valid/ready handshake.
//   fld : field requests out (field_code, field_value, end_of_message,
//         leftover), valid/ready handshake.
//   A byte is accepted whenever valid and ready are both high. It lands in
//   an input register; one pass of decode logic updates the parse state and
//   loads the result register once that register is free, so a field reaches
//   fld through the input and result registers. One byte per cycle is sustained
//   while fld takes each result; the only limit is the single result register on fld.
//   Bytes that finish nothing (prefix, partial words, pad) give no request
//   unless they carry last_byte, which always gives one request (code 29 if
//   nothing else), with leftover = received minus consumed, clamped.
//   When fld stalls, a byte that needs a result waits in the input register
//   and msg.ready drops; bytes that give no result keep flowing through.
//   After the last byte every counter and the phase return to their reset
//   values. arst_n clears the parse state and both valid flags at once.
module rpc_message_header_parser
	import rpcmh_pkg::*;
#(
	parameter int unsigned MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rpcmh_in_if.sink    msg,
	rpcmh_out_if.source fld
);

	localparam int unsigned RCV_W = $clog2(MAX_MSG_BYTES + 1);
	localparam int unsigned DIF_W = CONS_W + 2;
	localparam logic [RCV_W-1:0] RCV_MAX = RCV_W'(MAX_MSG_BYTES);
	localparam logic signed [DIF_W-1:0] LEFT_LO = -DIF_W'(65536);
	localparam logic signed [DIF_W-1:0] LEFT_HI = DIF_W'(65535);

	// input register
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// parse state
	ph_t                ph_q, ph_n;
	logic [1:0]         biw_q, biw_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic [OPQ_W-1:0]   opq_q, opq_n;
	logic [1:0]         pad_q, pad_n;
	logic [CONS_W-1:0]  cons_q, cons_n;
	logic [RCV_W-1:0]   rcv_q, rcv_n;
	logic               stop_q, stop_n;

	// decode results
	logic               have;
	logic [CODE_W-1:0]  code;
	logic [VALUE_W-1:0] val;
	logic [2:0]         size;
	logic [2:0]         biw_inc;
	logic [3:0]         pre_inc;
	logic [CONS_W-1:0]  extra;
	logic [CONS_W:0]    cons_tot;
	logic [DIF_W-1:0]   diff;
	logic signed [DIF_W-1:0] diff_s;
	logic signed [LEFT_W-1:0] left;
	logic [2:0]         size_n;

	logic emit, out_free, advance;

	assign emit     = have || last_s1;
	assign out_free = !fld.valid || fld.ready;
	assign advance  = v_s1 && (!emit || out_free);
	assign msg.ready = !v_s1 || advance;

	// one pass over the state for the byte in the input register
	always_comb begin
		ph_n   = ph_q;
		biw_n  = biw_q;
		acc_n  = acc_q;
		opq_n  = opq_q;
		pad_n  = pad_q;
		cons_n = cons_q;
		stop_n = stop_q;
		have   = 1'b0;
		code   = phase_code(ph_q);
		val    = '0;
		size   = phase_size(ph_q);
		biw_inc = {1'b0, biw_q} + 3'd1;
		pre_inc = opq_q[3:0] + 4'd1;

		rcv_n = (rcv_q < RCV_MAX) ? rcv_q + RCV_W'(1) : rcv_q;

		if (!stop_q) begin
			cons_n = (&cons_q) ? cons_q : cons_q + CONS_W'(1);
			case (ph_q)
				PH_PRE1, PH_PRE2: begin
					if (pre_inc >= PREFIX_LEN) begin
						opq_n = '0;
						ph_n  = ph_t'(ph_q + 5'd1);
					end else begin
						opq_n = OPQ_W'(pre_inc);
					end
				end
				PH_CDATA, PH_VDATA, PH_AVDATA: begin
					if (opq_q != '0) begin
						have  = 1'b1;
						val   = VALUE_W'(byte_s1);
						opq_n = opq_q - OPQ_W'(1);
					end else if (pad_q != 2'd0) begin
						pad_n = pad_q - 2'd1;
					end
					if (opq_n == '0 && pad_n == 2'd0) begin
						ph_n = (ph_q == PH_CDATA) ? PH_VFLAV
							: (ph_q == PH_VDATA) ? PH_ARGS : PH_ASTAT;
					end
				end
				PH_ARGS, PH_RESULTS: begin
					have = 1'b1;
					val  = VALUE_W'(byte_s1);
				end
				default: begin
					if (size == 3'd0) begin
						// no decode defined for this phase
						stop_n = 1'b1;
					end else if (biw_inc >= size) begin
						val   = {acc_q, byte_s1};
						biw_n = 2'd0;
						acc_n = '0;
						have  = 1'b1;
						case (ph_q)
							PH_HOST: begin
								ph_n  = PH_PRE2;
								opq_n = '0;
							end
							PH_MTYPE: begin
								if (val == MT_CALL) ph_n = PH_RPCVERS;
								else if (val == MT_REPLY) ph_n = PH_STAT;
								else stop_n = 1'b1;
							end
							PH_RPCVERS: begin
								if (val == RPC_VERS) ph_n = PH_PROG;
								else stop_n = 1'b1;
							end
							PH_CCNT, PH_VCNT, PH_AVCNT: begin
								opq_n = val;
								pad_n = 2'd0 - val[1:0];
								if (val == '0) begin
									ph_n = (ph_q == PH_CCNT) ? PH_VFLAV
										: (ph_q == PH_VCNT) ? PH_ARGS : PH_ASTAT;
								end else begin
									ph_n = ph_t'(ph_q + 5'd1);
								end
							end
							PH_STAT: begin
								if (val == MS_ACCEPTED) ph_n = PH_AVFLAV;
								else if (val == MS_DENIED) ph_n = PH_RSTAT;
								else stop_n = 1'b1;
							end
							PH_ASTAT: begin
								if (val == AS_SUCCESS) ph_n = PH_RESULTS;
								else if (val == AS_PROG_MISM) ph_n = PH_PLOW;
								else stop_n = 1'b1;
							end
							PH_RSTAT: begin
								if (val == RS_RPC_MISM) ph_n = PH_RLOW;
								else if (val == RS_AUTH_ERROR) ph_n = PH_AUTHSTAT;
								else stop_n = 1'b1;
							end
							PH_PHIGH, PH_RHIGH, PH_AUTHSTAT: stop_n = 1'b1;
							default: ph_n = ph_t'(ph_q + 5'd1);
						endcase
					end else begin
						biw_n = biw_inc[1:0];
						acc_n = {acc_q[ACC_W-9:0], byte_s1};
					end
				end
			endcase
		end

		// bytes still owed by the item in progress, counted as consumed at end
		size_n = phase_size(ph_n);
		if (stop_n) begin
			extra = '0;
		end else if (ph_n == PH_PRE1 || ph_n == PH_PRE2) begin
			extra = (opq_n != '0) ? CONS_W'(PREFIX_LEN - opq_n[3:0]) : '0;
		end else if (ph_n == PH_CDATA || ph_n == PH_VDATA || ph_n == PH_AVDATA) begin
			extra = CONS_W'(opq_n) + CONS_W'(pad_n);
		end else if (size_n != 3'd0 && biw_n != 2'd0) begin
			extra = CONS_W'(size_n - {1'b0, biw_n});
		end else begin
			extra = '0;
		end

		cons_tot = {1'b0, cons_n} + {1'b0, extra};
		diff     = DIF_W'(rcv_n) - {1'b0, cons_tot};
		diff_s   = $signed(diff);
		if (diff_s < LEFT_LO) left = LEFT_LO[LEFT_W-1:0];
		else if (diff_s > LEFT_HI) left = LEFT_HI[LEFT_W-1:0];
		else left = diff_s[LEFT_W-1:0];
	end

	// control: valid flags and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			fld.valid <= 1'b0;
			ph_q      <= PH_PRE1;
			biw_q     <= '0;
			acc_q     <= '0;
			opq_q     <= '0;
			pad_q     <= '0;
			cons_q    <= '0;
			rcv_q     <= '0;
			stop_q    <= 1'b0;
		end else begin
			if (msg.valid && msg.ready) v_s1 <= 1'b1;
			else if (advance) v_s1 <= 1'b0;

			if (advance && emit) fld.valid <= 1'b1;
			else if (fld.ready) fld.valid <= 1'b0;

			if (advance) begin
				if (last_s1) begin
					ph_q   <= PH_PRE1;
					biw_q  <= '0;
					acc_q  <= '0;
					opq_q  <= '0;
					pad_q  <= '0;
					cons_q <= '0;
					rcv_q  <= '0;
					stop_q <= 1'b0;
				end else begin
					ph_q   <= ph_n;
					biw_q  <= biw_n;
					acc_q  <= acc_n;
					opq_q  <= opq_n;
					pad_q  <= pad_n;
					cons_q <= cons_n;
					rcv_q  <= rcv_n;
					stop_q <= stop_n;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
		if (advance && emit) begin
			fld.field_code     <= have ? code : FC_END;
			fld.field_value    <= have ? val : '0;
			fld.end_of_message <= last_s1;
			fld.leftover       <= last_s1 ? left : '0;
		end
	end

endmodule

// ===== tb/rpcmh_field_checker.sv =====
// Field checker: predicts parser fields from accepted bytes and compares them.
module rpcmh_field_checker
	import rpcmh_pkg::*;
#(
	parameter int unsigned MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rpcmh_in_if  msg,
	rpcmh_out_if fld,
	output int   fail_count,
	output int   pending,
	output int   fields_checked,
	output int   messages_checked
);

	localparam longint LEFT_LO     = -65536;
	localparam longint LEFT_HI     = 65535;
	localparam int     MAX_REPORTS = 40;

	typedef struct packed {
		logic [CODE_W-1:0]        code;
		logic [VALUE_W-1:0]       value;
		logic                     eom;
		logic signed [LEFT_W-1:0] left;
	} field_t;

	// parse state of the predictor
	ph_t              phase;
	int unsigned      word_pos;
	logic [ACC_W-1:0] acc;
	logic [OPQ_W-1:0] body_left;   // also counts prefix bytes seen
	int unsigned      pad_left;
	longint           consumed;
	int unsigned      received;
	bit               halted;

	field_t fields_due[$];

	function automatic int unsigned word_len(ph_t p);
		case (p)
			PH_PORT, PH_LPORT: return 2;
			PH_PRE1, PH_PRE2, PH_CDATA, PH_VDATA, PH_AVDATA, PH_ARGS, PH_RESULTS: return 0;
			default: return 4;
		endcase
	endfunction

	// both prefixes and the remote host report code 0
	function automatic logic [CODE_W-1:0] code_of(ph_t p);
		return (p < PH_LHOST) ? '0 : CODE_W'(int'(p) - 2);
	endfunction

	task automatic clear_parse();
		phase     = PH_PRE1;
		word_pos  = 0;
		acc       = '0;
		body_left = '0;
		pad_left  = 0;
		consumed  = 0;
		received  = 0;
		halted    = 1'b0;
	endtask

	task automatic open_body(input logic [OPQ_W-1:0] cnt, input ph_t data_ph,
			input ph_t next_ph);
		body_left = cnt;
		pad_left  = (4 - int'(cnt[1:0])) % 4;
		phase     = (cnt == 0) ? next_ph : data_ph;
	endtask

	task automatic word_done(input logic [VALUE_W-1:0] v);
		case (phase)
			PH_HOST: begin
				phase     = PH_PRE2;
				body_left = '0;
			end
			PH_MTYPE: begin
				if (v == MT_CALL) phase = PH_RPCVERS;
				else if (v == MT_REPLY) phase = PH_STAT;
				else halted = 1'b1;
			end
			PH_RPCVERS: begin
				if (v == RPC_VERS) phase = PH_PROG;
				else halted = 1'b1;
			end
			PH_CCNT:  open_body(v, PH_CDATA, PH_VFLAV);
			PH_VCNT:  open_body(v, PH_VDATA, PH_ARGS);
			PH_AVCNT: open_body(v, PH_AVDATA, PH_ASTAT);
			PH_STAT: begin
				if (v == MS_ACCEPTED) phase = PH_AVFLAV;
				else if (v == MS_DENIED) phase = PH_RSTAT;
				else halted = 1'b1;
			end
			PH_ASTAT: begin
				if (v == AS_SUCCESS) phase = PH_RESULTS;
				else if (v == AS_PROG_MISM) phase = PH_PLOW;
				else halted = 1'b1;
			end
			PH_RSTAT: begin
				if (v == RS_RPC_MISM) phase = PH_RLOW;
				else if (v == RS_AUTH_ERROR) phase = PH_AUTHSTAT;
				else halted = 1'b1;
			end
			PH_PHIGH, PH_RHIGH, PH_AUTHSTAT: halted = 1'b1;
			default: phase = ph_t'(phase + 1);
		endcase
	endtask

	// one accepted byte: advance the parse and queue the field it yields
	task automatic take_byte(input logic [BYTE_W-1:0] b, input logic l);
		field_t      f;
		bit          have;
		int unsigned sz;
		longint      owed;
		longint      left;
		have = 1'b0;
		f    = '0;
		if (received < MAX_MSG_BYTES) received++;
		if (!halted) begin
			consumed++;
			sz = word_len(phase);
			case (phase)
				PH_PRE1, PH_PRE2: begin
					body_left++;
					if (body_left >= PREFIX_LEN) begin
						body_left = '0;
						phase     = ph_t'(phase + 1);
					end
				end
				PH_CDATA, PH_VDATA, PH_AVDATA: begin
					if (body_left > 0) begin
						have    = 1'b1;
						f.code  = code_of(phase);
						f.value = {24'd0, b};
						body_left--;
					end else if (pad_left > 0) begin
						pad_left--;
					end
					if (body_left == 0 && pad_left == 0)
						phase = (phase == PH_CDATA) ? PH_VFLAV :
							(phase == PH_VDATA) ? PH_ARGS : PH_ASTAT;
				end
				PH_ARGS, PH_RESULTS: begin
					have    = 1'b1;
					f.code  = code_of(phase);
					f.value = {24'd0, b};
				end
				default: begin
					word_pos++;
					if (word_pos >= sz) begin
						f.value  = {acc, b};
						f.code   = code_of(phase);
						have     = 1'b1;
						word_pos = 0;
						acc      = '0;
						word_done(f.value);
					end else begin
						acc = {acc[15:0], b};
					end
				end
			endcase
		end
		if (l) begin
			// a cut message still owes the rest of the item it was in
			owed = 0;
			if (!halted) begin
				case (phase)
					PH_PRE1, PH_PRE2:
						owed = (body_left > 0) ? longint'(PREFIX_LEN - body_left) : 0;
					PH_CDATA, PH_VDATA, PH_AVDATA:
						owed = longint'(body_left) + pad_left;
					default:
						owed = (word_len(phase) != 0 && word_pos > 0) ?
							word_len(phase) - word_pos : 0;
				endcase
			end
			left = longint'(received) - (consumed + owed);
			if (left < LEFT_LO) left = LEFT_LO;
			if (left > LEFT_HI) left = LEFT_HI;
			f.left = left[LEFT_W-1:0];
			f.eom  = 1'b1;
			if (!have) begin
				f.code  = FC_END;
				f.value = '0;
			end
		end
		if (have || l) fields_due.push_back(f);
		if (l) clear_parse();
	endtask

	always @(posedge clk or negedge arst_n) begin
		field_t seen;
		field_t want;
		if (!arst_n) begin
			clear_parse();
			fields_due.delete();
			fail_count       = 0;
			fields_checked   = 0;
			messages_checked = 0;
		end else begin
			if (msg.valid && msg.ready)
				take_byte(msg.data_byte, msg.last_byte);
			if (fld.valid && fld.ready) begin
				seen = '{fld.field_code, fld.field_value, fld.end_of_message, fld.leftover};
				fields_checked++;
				if (fields_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected field: code %0d value %08h end %0b leftover %0d",
							$time, seen.code, seen.value, seen.eom, seen.left);
				end else begin
					want = fields_due.pop_front();
					if (seen.code !== want.code || seen.value !== want.value ||
							seen.eom !== want.eom || seen.left !== want.left) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: field mismatch: expected code %0d value %08h end %0b ",
								$time, want.code, want.value, want.eom,
								"leftover %0d, got code %0d value %08h end %0b leftover %0d",
								want.left, seen.code, seen.value, seen.eom, seen.left);
					end
				end
				if (seen.eom === 1'b1) messages_checked++;
			end
		end
		pending = fields_due.size();
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: feeds RPC messages to the parser and gives the verdict.
module tb;
	import rpcmh_pkg::*;

	localparam int     RUN_BYTES     = 1550;    // bytes sent in all, directed messages included
	localparam int     QUIET_TAIL    = 200;     // last bytes sent with no idling
	localparam int     HOLD_CYCLES   = 80;      // one long stall of the field channel
	localparam int     DRAIN_CYCLES  = 16;
	localparam longint CYCLE_LIMIT   = 200_000;

	// message shapes; one of each is sent first, then they are drawn at random
	typedef enum int {
		MK_CALL, MK_BAD_VERS, MK_BAD_MTYPE, MK_ACC_SUCCESS, MK_PROG_MISM,
		MK_ACC_OTHER, MK_RPC_MISM, MK_AUTH_ERR, MK_REJ_OTHER, MK_BAD_STAT,
		MK_HUGE_BODY, MK_NOISE
	} msg_kind_t;

	localparam int NUM_KINDS = MK_NOISE + 1;

	logic clk;
	logic arst_n;

	rpcmh_in_if  msg ();
	rpcmh_out_if fld ();

	int     fail_count;
	int     pending;
	int     fields_checked;
	int     messages_checked;
	longint cycles = 0;

	// traffic shaping flags shared by the driving processes
	bit quiet      = 1'b0;
	bit tx_busy    = 1'b1;
	bit rx_busy    = 1'b1;
	bit hold_armed = 1'b0;
	bit hold_done  = 1'b0;

	int bytes_sent = 0;
	int msgs_sent  = 0;

	logic [7:0] frame[$];   // message under construction

	rpc_message_header_parser #(
		.MAX_MSG_BYTES(MAX_MSG_BYTES_DEF)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.msg   (msg),
		.fld   (fld)
	);

	rpcmh_field_checker #(
		.MAX_MSG_BYTES(MAX_MSG_BYTES_DEF)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.msg             (msg),
		.fld             (fld),
		.fail_count      (fail_count),
		.pending         (pending),
		.fields_checked  (fields_checked),
		.messages_checked(messages_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// watchdog
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d fields still due", cycles, pending);
		$display("tb: failure");
		$finish;
	end

	// field channel: ready in random bursts, calm stretches, and one long
	// hold so the parser backs up and drops msg.ready
	initial begin
		int k;
		fld.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0) rx_busy = !rx_busy;
			if (hold_armed && !hold_done) begin
				fld.ready <= 1'b0;
				k         = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (!quiet && rx_busy && $urandom_range(0, 3) == 0) begin
				fld.ready <= 1'b0;
				k         = $urandom_range(1, 7);
			end else begin
				fld.ready <= 1'b1;
				k         = $urandom_range(1, 8);
			end
			repeat (k) @(posedge clk);
		end
	end

	// Offer one byte. Ready is sampled on the falling edge, where it is
	// stable up to the next rising edge that completes the handshake.
	task automatic push_byte(input logic [7:0] b, input logic l);
		bit took;
		if (!quiet && tx_busy && $urandom_range(0, 5) == 0) begin
			msg.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		msg.valid     <= 1'b1;
		msg.data_byte <= b;
		msg.last_byte <= l;
		do begin
			@(negedge clk);
			took = msg.ready;
			@(posedge clk);
		end while (!took);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++)
			push_byte(frame[i], i == frame.size() - 1);
		msgs_sent++;
	endtask

	// --- message construction -------------------------------------------

	task automatic put_word(input logic [31:0] w, input int n);
		for (int i = n - 1; i >= 0; i--) frame.push_back(w[8*i +: 8]);
	endtask

	task automatic put_fill(input int n);
		for (int i = 0; i < n; i++) frame.push_back(8'($urandom()));
	endtask

	// words lean on the extremes now and then
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// a status word that none of the decoded branches accept
	function automatic logic [31:0] other_than(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] w;
		do begin
			w = ($urandom_range(0, 2) == 0) ? pick_word() : 32'($urandom_range(0, 6));
		end while (w == a || w == b);
		return w;
	endfunction

	function automatic int body_len();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
	endfunction

	// opaque: count word, body, then pad to a 4-byte boundary
	task automatic put_opaque(input int n);
		put_word(32'(n), 4);
		put_fill(n + (4 - n % 4) % 4);
	endtask

	// prefix, remote host, prefix, local host, ports, xid, message type
	task automatic put_header(input logic [31:0] mtype);
		put_fill(PREFIX_LEN);
		put_word(pick_word(), 4);
		put_fill(PREFIX_LEN);
		put_word(pick_word(), 4);
		put_word(pick_word(), 2);
		put_word(pick_word(), 2);
		put_word(pick_word(), 4);
		put_word(mtype, 4);
	endtask

	// call up to and including the credential flavor
	task automatic put_call_head();
		put_header(MT_CALL);
		put_word(RPC_VERS, 4);
		repeat (4) put_word(pick_word(), 4);
	endtask

	// accepted reply up to and including the verifier
	task automatic put_accepted();
		put_header(MT_REPLY);
		put_word(MS_ACCEPTED, 4);
		put_word(pick_word(), 4);
		put_opaque(body_len());
	endtask

	task automatic build_frame(input msg_kind_t kind);
		logic [31:0] huge;
		frame.delete();
		case (kind)
			MK_CALL: begin
				put_call_head();
				put_opaque(body_len());
				put_word(pick_word(), 4);
				put_opaque(body_len());
				put_fill($urandom_range(0, 12));
			end
			MK_BAD_VERS: begin
				put_header(MT_CALL);
				put_word(other_than(RPC_VERS, RPC_VERS), 4);
				put_fill($urandom_range(0, 8));
			end
			MK_BAD_MTYPE: begin
				put_header(other_than(MT_CALL, MT_REPLY));
				put_fill($urandom_range(0, 8));
			end
			MK_ACC_SUCCESS: begin
				put_accepted();
				put_word(AS_SUCCESS, 4);
				put_fill($urandom_range(0, 12));
			end
			MK_PROG_MISM: begin
				put_accepted();
				put_word(AS_PROG_MISM, 4);
				put_word(pick_word(), 4);
				put_word(pick_word(), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_ACC_OTHER: begin
				put_accepted();
				put_word(other_than(AS_SUCCESS, AS_PROG_MISM), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_RPC_MISM: begin
				put_header(MT_REPLY);
				put_word(MS_DENIED, 4);
				put_word(RS_RPC_MISM, 4);
				put_word(pick_word(), 4);
				put_word(pick_word(), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_AUTH_ERR: begin
				put_header(MT_REPLY);
				put_word(MS_DENIED, 4);
				put_word(RS_AUTH_ERROR, 4);
				put_word(pick_word(), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_REJ_OTHER: begin
				put_header(MT_REPLY);
				put_word(MS_DENIED, 4);
				put_word(other_than(RS_RPC_MISM, RS_AUTH_ERROR), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_BAD_STAT: begin
				put_header(MT_REPLY);
				put_word(other_than(MS_ACCEPTED, MS_DENIED), 4);
				put_fill($urandom_range(0, 4));
			end
			MK_HUGE_BODY: begin
				// body far longer than what follows: leftover clamps at its low end
				huge = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : (32'h0001_0000 | $urandom());
				case ($urandom_range(0, 2))
					0: put_call_head();
					1: begin
						put_call_head();
						put_opaque(body_len());
						put_word(pick_word(), 4);
					end
					default: begin
						put_header(MT_REPLY);
						put_word(MS_ACCEPTED, 4);
						put_word(pick_word(), 4);
					end
				endcase
				put_word(huge, 4);
				put_fill($urandom_range(0, 10));
			end
			default: put_fill($urandom_range(1, 60));   // noise
		endcase
		// cut some messages short anywhere, including inside prefixes and words
		if (kind != MK_NOISE && $urandom_range(0, 4) == 0) begin
			int cut;
			cut = $urandom_range(1, frame.size());
			while (frame.size() > cut) void'(frame.pop_back());
		end
	endtask

	// --- stimulus --------------------------------------------------------

	initial begin
		msg_kind_t kind;
		arst_n        <= 1'b0;
		msg.valid     <= 1'b0;
		msg.data_byte <= '0;
		msg.last_byte <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte messages at both byte extremes
		frame = '{8'hFF};
		send_frame();
		frame = '{8'h00};
		send_frame();
		// ends exactly on the end of the first prefix
		frame.delete();
		repeat (6) put_word(32'h00FF, 2);
		send_frame();
		// ends two bytes into the remote host word
		frame.delete();
		repeat (6) put_word(32'hFF00, 2);
		put_word(32'hA55A, 2);
		send_frame();

		for (int m = 0; bytes_sent < RUN_BYTES; m++) begin
			tx_busy = ($urandom_range(0, 2) != 0);
			if (m == 6) hold_armed = 1'b1;
			if (bytes_sent + QUIET_TAIL >= RUN_BYTES) quiet = 1'b1;
			kind = (m < NUM_KINDS) ? msg_kind_t'(m) : msg_kind_t'($urandom_range(0, NUM_KINDS - 1));
			build_frame(kind);
			send_frame();
		end
		msg.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d bytes in %0d messages of every shape, %0d fields checked,",
			bytes_sent, msgs_sent, fields_checked);
		$display("run: %0d message ends seen, %0d mismatches", messages_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
